@@ hw/rtl/tpsw_pkg.sv @@
package tpsw_pkg;

    // width of the running time counter; the count saturates at 2^TIME_BITS-1,
    // never beyond the 32-bit elapsed field
    localparam int unsigned TIME_BITS = 32;
    localparam logic [31:0] TIME_CAP  = (TIME_BITS >= 32) ? 32'hFFFF_FFFF
                                      : 32'((64'd1 << TIME_BITS) - 64'd1);

    // hold counters and thresholds
    localparam int unsigned HOLD_BITS = 16;
    localparam logic [HOLD_BITS-1:0] HOLD_MAX = '1;

    // configuration register map
    localparam int unsigned CFG_IDX_BITS  = 1;
    localparam int unsigned CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER_HOLD = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EXIT_HOLD    = 1'b1;

    localparam logic [HOLD_BITS-1:0] TRIGGER_HOLD_RST = 16'd500;
    localparam logic [HOLD_BITS-1:0] EXIT_HOLD_RST    = 16'd3000;

    // one tick of pad and button levels
    typedef struct packed {
        logic left_pad;
        logic right_pad;
        logic reset_button;
    } t_in_item;

    // per-tick status
    typedef struct packed {
        logic        running;
        logic [31:0] elapsed_ms;
        logic        stop_valid;
        logic [31:0] stopped_time_ms;
        logic        led_on;
        logic        exit_request;
        logic        redisplay;
    } t_out_item;

endpackage

@@ hw/rtl/tpsw_core.sv @@
module tpsw_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  tpsw_pkg::t_in_item                i_item,
    input  logic [tpsw_pkg::HOLD_BITS-1:0]    i_trigger_hold,
    input  logic [tpsw_pkg::HOLD_BITS-1:0]    i_exit_hold,
    output tpsw_pkg::t_out_item               o_result
);

    logic                           r_is_running;
    logic [31:0]                    r_run_cnt;
    logic                           r_pads_armed;
    logic [tpsw_pkg::HOLD_BITS-1:0] r_pad_cnt;
    logic                           r_btn_armed;
    logic [tpsw_pkg::HOLD_BITS-1:0] r_btn_cnt;
    logic [2:0]                     r_prev_levels;
    logic                           r_lamp;
    logic [31:0]                    r_last_time;

    logic                           n_is_running;
    logic [31:0]                    n_run_cnt;
    logic                           n_pads_armed;
    logic [tpsw_pkg::HOLD_BITS-1:0] n_pad_cnt;
    logic                           n_btn_armed;
    logic [tpsw_pkg::HOLD_BITS-1:0] n_btn_cnt;
    logic                           n_lamp;
    logic [31:0]                    n_last_time;

    logic [2:0] levels;
    logic [2:0] changed;
    logic       stop_now;
    logic       exit_now;
    logic       redraw;

    assign levels  = {i_item.reset_button, i_item.right_pad, i_item.left_pad};
    assign changed = levels ^ r_prev_levels;

    // counting, then pad handler, then button handler
    always_comb begin
        n_is_running = r_is_running;
        n_run_cnt    = r_run_cnt;
        n_pads_armed = r_pads_armed;
        n_pad_cnt    = r_pad_cnt;
        n_btn_armed  = r_btn_armed;
        n_btn_cnt    = r_btn_cnt;
        n_lamp       = r_lamp;
        n_last_time  = r_last_time;
        stop_now     = 1'b0;
        exit_now     = 1'b0;
        redraw       = 1'b0;

        // saturating counters
        if (r_is_running && (r_run_cnt < tpsw_pkg::TIME_CAP)) begin
            n_run_cnt = r_run_cnt + 32'd1;
        end
        if (r_pads_armed && (r_pad_cnt != tpsw_pkg::HOLD_MAX)) begin
            n_pad_cnt = r_pad_cnt + tpsw_pkg::HOLD_BITS'(1);
        end
        if (r_btn_armed && (r_btn_cnt != tpsw_pkg::HOLD_MAX)) begin
            n_btn_cnt = r_btn_cnt + tpsw_pkg::HOLD_BITS'(1);
        end

        // pad level change
        if (changed[0] || changed[1]) begin
            if (!r_pads_armed) begin
                if (levels[0] && levels[1]) begin
                    n_pads_armed = 1'b1;
                    n_pad_cnt    = '0;
                end
            end else if (!levels[0] || !levels[1]) begin
                if (r_is_running) begin
                    n_pads_armed = 1'b0;
                    n_is_running = 1'b0;
                    n_last_time  = n_run_cnt;
                    n_run_cnt    = '0;
                    stop_now     = 1'b1;
                end else if (n_pad_cnt >= i_trigger_hold) begin
                    n_pads_armed = 1'b0;
                    n_is_running = 1'b1;
                    n_run_cnt    = '0;
                end
            end
        end

        // reset button level change, release ignored while timing
        if (changed[2]) begin
            if (levels[2]) begin
                n_lamp      = 1'b1;
                n_btn_armed = 1'b1;
                n_btn_cnt   = '0;
            end else if (!n_is_running && n_btn_armed) begin
                if ((n_btn_cnt >= i_trigger_hold) && (n_btn_cnt < i_exit_hold)) begin
                    n_lamp       = 1'b0;
                    n_btn_armed  = 1'b0;
                    redraw       = 1'b1;
                    n_is_running = 1'b0;
                    n_run_cnt    = '0;
                end else if (n_btn_cnt >= i_exit_hold) begin
                    n_lamp      = 1'b0;
                    n_btn_armed = 1'b0;
                    exit_now    = 1'b1;
                end
            end
        end
    end

    // status for this tick
    always_comb begin
        o_result.running         = n_is_running;
        o_result.elapsed_ms      = n_is_running ? n_run_cnt : 32'd0;
        o_result.stop_valid      = stop_now;
        o_result.stopped_time_ms = n_last_time;
        o_result.led_on          = n_lamp;
        o_result.exit_request    = exit_now;
        o_result.redisplay       = redraw;
    end

    // state commits when a tick is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_running  <= 1'b0;
            r_run_cnt     <= '0;
            r_pads_armed  <= 1'b0;
            r_pad_cnt     <= '0;
            r_btn_armed   <= 1'b0;
            r_btn_cnt     <= '0;
            r_prev_levels <= '0;
            r_lamp        <= 1'b0;
            r_last_time   <= '0;
        end else if (i_step) begin
            r_is_running  <= n_is_running;
            r_run_cnt     <= n_run_cnt;
            r_pads_armed  <= n_pads_armed;
            r_pad_cnt     <= n_pad_cnt;
            r_btn_armed   <= n_btn_armed;
            r_btn_cnt     <= n_btn_cnt;
            r_prev_levels <= levels;
            r_lamp        <= n_lamp;
            r_last_time   <= n_last_time;
        end
    end

endmodule

@@ hw/rtl/two_pad_stopwatch_control.sv @@
// Two-pad stopwatch control. Each input transaction is one millisecond tick
// carrying the two pad levels and the reset button level; each tick yields
// exactly one status transaction (running flag, elapsed time, stop event with
// the measured time, lamp, exit request, redisplay). The block takes one tick
// per clock cycle while o_in_ready is high: a tick is captured in an input
// register, evaluated against the stopwatch state in one pass, and the status
// lands in a result register; both stages advance whenever the result register
// is empty or being taken, so back-pressure on the output stalls the input
// only once both stages are full. Hold thresholds are set through the write
// port: index 0 is the trigger hold (reset 500 ms), index 1 the exit hold
// (reset 3000 ms); write them only while no tick is in flight.
module two_pad_stopwatch_control (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  tpsw_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output tpsw_pkg::t_out_item                   o_out_data,
    input  logic                                  i_cfg_we,
    input  logic [tpsw_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [tpsw_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    logic                           r_in_valid;
    tpsw_pkg::t_in_item             r_in_item;
    logic                           r_out_valid;
    tpsw_pkg::t_out_item            r_out_item;
    logic [tpsw_pkg::HOLD_BITS-1:0] r_trigger_hold;
    logic [tpsw_pkg::HOLD_BITS-1:0] r_exit_hold;

    logic                advance;
    logic                step;
    tpsw_pkg::t_out_item result;

    assign advance     = !r_out_valid || i_out_ready;
    assign step        = advance && r_in_valid;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_hold <= tpsw_pkg::TRIGGER_HOLD_RST;
            r_exit_hold    <= tpsw_pkg::EXIT_HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tpsw_pkg::CFG_TRIGGER_HOLD: begin
                    r_trigger_hold <= i_cfg_data[tpsw_pkg::HOLD_BITS-1:0];
                end
                tpsw_pkg::CFG_EXIT_HOLD: begin
                    r_exit_hold <= i_cfg_data[tpsw_pkg::HOLD_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    // stopwatch state and per-tick evaluation
    tpsw_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_item         (r_in_item),
        .i_trigger_hold (r_trigger_hold),
        .i_exit_hold    (r_exit_hold),
        .o_result       (result)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

endmodule

@@ hw/rtl/tpsw_checker.sv @@
module tpsw_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input tpsw_pkg::t_out_item                   o_out_data
);

    // a stalled status transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("status transaction changed while stalled");

    // elapsed time only shows while timing
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.running |-> o_out_data.elapsed_ms == 32'd0)
        else $error("elapsed time nonzero while idle");

    // a stop leaves the timer idle
    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.stop_valid |-> !o_out_data.running)
        else $error("stop reported while still running");

    // a completed reset press turns the lamp off, and only one kind completes
    a_press_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.redisplay || o_out_data.exit_request)
        |-> !o_out_data.led_on && !(o_out_data.redisplay && o_out_data.exit_request))
        else $error("reset press completion inconsistent");

endmodule

bind two_pad_stopwatch_control tpsw_checker u_tpsw_checker (.*);

@@ dv/two_pad_stopwatch_control_tb.sv @@
module two_pad_stopwatch_control_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CAP   = 80;
    localparam int PRINT_CAP  = 100;

    // status predictor and expected status queue
    class stopwatch_scoreboard;
        logic [tpsw_pkg::HOLD_BITS-1:0] trigger_hold;
        logic [tpsw_pkg::HOLD_BITS-1:0] exit_hold;
        logic                           running;
        logic [31:0]                    run_count;
        logic                           pads_armed;
        logic [tpsw_pkg::HOLD_BITS-1:0] pad_hold;
        logic                           button_armed;
        logic [tpsw_pkg::HOLD_BITS-1:0] button_hold;
        logic [2:0]                     prev_levels;
        logic                           lamp;
        logic [31:0]                    last_stop;
        tpsw_pkg::t_out_item            expected_status[$];
        int                             errors;
        int                             checked;

        function new();
            trigger_hold = tpsw_pkg::TRIGGER_HOLD_RST;
            exit_hold    = tpsw_pkg::EXIT_HOLD_RST;
            running      = 1'b0;
            run_count    = '0;
            pads_armed   = 1'b0;
            pad_hold     = '0;
            button_armed = 1'b0;
            button_hold  = '0;
            prev_levels  = '0;
            lamp         = 1'b0;
            last_stop    = '0;
            errors       = 0;
            checked      = 0;
        endfunction

        function void set_threshold(logic [tpsw_pkg::CFG_IDX_BITS-1:0] idx,
                                    logic [tpsw_pkg::HOLD_BITS-1:0] value);
            if (idx == tpsw_pkg::CFG_TRIGGER_HOLD) trigger_hold = value;
            else exit_hold = value;
        endfunction

        // advance one tick and queue the status it produces
        function void note_tick(tpsw_pkg::t_in_item lv);
            logic [2:0]          levels;
            logic [2:0]          changed;
            logic                stop_now;
            logic                exit_now;
            logic                redraw;
            tpsw_pkg::t_out_item st;
            levels   = {lv.reset_button, lv.right_pad, lv.left_pad};
            changed  = levels ^ prev_levels;
            stop_now = 1'b0;
            exit_now = 1'b0;
            redraw   = 1'b0;

            // saturating counters
            if (running && run_count < tpsw_pkg::TIME_CAP) run_count++;
            if (pads_armed && pad_hold != tpsw_pkg::HOLD_MAX) pad_hold++;
            if (button_armed && button_hold != tpsw_pkg::HOLD_MAX) button_hold++;

            // pad edges
            if (changed[1:0] != 2'b00) begin
                if (!pads_armed) begin
                    if (lv.left_pad && lv.right_pad) begin
                        pads_armed = 1'b1;
                        pad_hold   = '0;
                    end
                end else if (!lv.left_pad || !lv.right_pad) begin
                    if (running) begin
                        pads_armed = 1'b0;
                        running    = 1'b0;
                        last_stop  = run_count;
                        run_count  = '0;
                        stop_now   = 1'b1;
                    end else if (pad_hold >= trigger_hold) begin
                        pads_armed = 1'b0;
                        running    = 1'b1;
                        run_count  = '0;
                    end
                end
            end

            // button edges, after the pads
            if (changed[2]) begin
                if (lv.reset_button) begin
                    lamp         = 1'b1;
                    button_armed = 1'b1;
                    button_hold  = '0;
                end else if (!running && button_armed) begin
                    if (button_hold >= trigger_hold && button_hold < exit_hold) begin
                        lamp         = 1'b0;
                        button_armed = 1'b0;
                        redraw       = 1'b1;
                        running      = 1'b0;
                        run_count    = '0;
                    end else if (button_hold >= exit_hold) begin
                        lamp         = 1'b0;
                        button_armed = 1'b0;
                        exit_now     = 1'b1;
                    end
                end
            end

            prev_levels = levels;

            st.running         = running;
            st.elapsed_ms      = running ? run_count : 32'd0;
            st.stop_valid      = stop_now;
            st.stopped_time_ms = last_stop;
            st.led_on          = lamp;
            st.exit_request    = exit_now;
            st.redisplay       = redraw;
            expected_status.push_back(st);
        endfunction

        task report_mismatch(string msg);
            if (errors < PRINT_CAP) $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("status %0d %s got %0h want %0h",
                                          checked, name, got, want));
        endtask

        // compare one status transaction with the oldest expectation
        task check_status(tpsw_pkg::t_out_item got);
            tpsw_pkg::t_out_item want;
            if (expected_status.size() == 0) begin
                report_mismatch("status transaction with nothing expected");
                return;
            end
            want = expected_status.pop_front();
            check_field("running", 32'(got.running), 32'(want.running));
            check_field("elapsed_ms", got.elapsed_ms, want.elapsed_ms);
            check_field("stop_valid", 32'(got.stop_valid), 32'(want.stop_valid));
            check_field("stopped_time_ms", got.stopped_time_ms, want.stopped_time_ms);
            check_field("led_on", 32'(got.led_on), 32'(want.led_on));
            check_field("exit_request", 32'(got.exit_request), 32'(want.exit_request));
            check_field("redisplay", 32'(got.redisplay), 32'(want.redisplay));
            checked++;
        endtask
    endclass

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    tpsw_pkg::t_in_item                 in_data   = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    tpsw_pkg::t_out_item                out_data;
    logic                               cfg_we    = 1'b0;
    logic [tpsw_pkg::CFG_IDX_BITS-1:0]  cfg_idx   = '0;
    logic [tpsw_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;

    stopwatch_scoreboard sb;
    tpsw_pkg::t_in_item  cur_levels = '0;
    int                  ticks_sent = 0;
    int                  burst_left = 0;
    int                  thr_trigger = int'(tpsw_pkg::TRIGGER_HOLD_RST);
    int                  thr_exit    = int'(tpsw_pkg::EXIT_HOLD_RST);
    int                  idle_cycles = 0;
    int                  stall_asked = 0;
    int                  stall_granted = 0;
    int                  hold_off_left = 0;
    int                  rx_mode = 0;
    int                  mode_left = 0;
    int                  rx_phase = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    two_pad_stopwatch_control DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // receiver: stall pattern in modes, plus long hold-offs on request
    always @(posedge clk) begin
        rx_phase++;
        if (hold_off_left > 0) begin
            out_ready <= 1'b0;
            hold_off_left--;
        end else if (rst_n && stall_granted != stall_asked) begin
            stall_granted++;
            hold_off_left = $urandom_range(60, 120);
            out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= (rx_phase % 3 == 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // transaction monitor and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) sb.check_status(out_data);
            if (in_valid && in_ready) sb.note_tick(in_data);
            if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic tpsw_pkg::t_in_item mk_tick(logic l, logic r, logic b);
        tpsw_pkg::t_in_item t;
        t.left_pad     = l;
        t.right_pad    = r;
        t.reset_button = b;
        return t;
    endfunction

    // hold length near the current thresholds, short otherwise
    function automatic int pick_hold();
        int d;
        case ($urandom_range(0, 7))
            0: d = 1;
            1: d = thr_trigger - 1;
            2: d = thr_trigger;
            3: d = thr_trigger + 1;
            4: d = thr_exit - 1;
            5: d = thr_exit;
            6: d = thr_exit + 1;
            default: d = $urandom_range(1, 8);
        endcase
        if (d < 1 || d > HOLD_CAP) d = $urandom_range(1, 8);
        return d;
    endfunction

    // offer one tick, then maybe a gap at the end of a burst
    task automatic send_tick(input tpsw_pkg::t_in_item lv);
        int gap;
        in_valid <= 1'b1;
        in_data  <= lv;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ticks_sent++;
        cur_levels = lv;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic hold_levels(input tpsw_pkg::t_in_item lv, input int n);
        repeat (n) send_tick(lv);
    endtask

    // stop offering and wait for every expected status
    task automatic drain_status();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_status.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_thresholds(input int trig, input int ext);
        drain_status();
        cfg_we   <= 1'b1;
        cfg_idx  <= tpsw_pkg::CFG_TRIGGER_HOLD;
        cfg_data <= tpsw_pkg::CFG_DATA_BITS'(trig);
        @(posedge clk);
        cfg_idx  <= tpsw_pkg::CFG_EXIT_HOLD;
        cfg_data <= tpsw_pkg::CFG_DATA_BITS'(ext);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_threshold(tpsw_pkg::CFG_TRIGGER_HOLD, tpsw_pkg::HOLD_BITS'(trig));
        sb.set_threshold(tpsw_pkg::CFG_EXIT_HOLD, tpsw_pkg::HOLD_BITS'(ext));
        thr_trigger = trig;
        thr_exit    = ext;
    endtask

    // mostly arm/release and press/release sequences, some noise
    task automatic random_phase(input int n_ticks);
        int                 start;
        int                 pick;
        logic               b;
        tpsw_pkg::t_in_item rel;
        start = ticks_sent;
        while (ticks_sent - start < n_ticks) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                b = cur_levels.reset_button ^ ($urandom_range(0, 3) == 0);
                hold_levels(mk_tick(1'b1, 1'b1, b), pick_hold());
                case ($urandom_range(0, 2))
                    0: rel = mk_tick(1'b0, 1'b0, b);
                    1: rel = mk_tick(1'b1, 1'b0, b);
                    default: rel = mk_tick(1'b0, 1'b1, b);
                endcase
                hold_levels(rel, $urandom_range(1, 10));
            end else if (pick < 70) begin
                hold_levels(mk_tick(cur_levels.left_pad, cur_levels.right_pad, 1'b1),
                            pick_hold());
                hold_levels(mk_tick(cur_levels.left_pad, cur_levels.right_pad, 1'b0),
                            $urandom_range(1, 6));
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 6))
                    send_tick(tpsw_pkg::t_in_item'(3'($urandom_range(0, 7))));
            end else begin
                hold_levels(mk_tick(1'b1, 1'b1, 1'b1), pick_hold());
                hold_levels(mk_tick(1'b0, 1'b0, 1'b0), $urandom_range(1, 5));
            end
        end
    endtask

    initial begin
        sb = new();
        burst_left = $urandom_range(1, 40);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // levels high at power-up count as edges; early releases keep arming
        send_tick(mk_tick(1'b1, 1'b1, 1'b1));
        send_tick(mk_tick(1'b1, 1'b1, 1'b1));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0));
        send_tick(mk_tick(1'b1, 1'b0, 1'b0));
        send_tick(mk_tick(1'b0, 1'b1, 1'b0));
        send_tick(mk_tick(1'b1, 1'b1, 1'b0));
        send_tick(mk_tick(1'b0, 1'b1, 1'b1));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0));

        // start at reset thresholds, button while timing, then stop
        hold_levels(mk_tick(1'b1, 1'b1, 1'b0), 500);
        hold_levels(mk_tick(1'b0, 1'b0, 1'b0), 20);
        hold_levels(mk_tick(1'b0, 1'b0, 1'b1), 5);
        hold_levels(mk_tick(1'b0, 1'b0, 1'b0), 3);
        hold_levels(mk_tick(1'b1, 1'b1, 1'b0), 4);
        hold_levels(mk_tick(1'b0, 1'b0, 1'b0), 2);

        // short press, press just under exit, exit press, pad hold one short
        set_thresholds(10, 40);
        hold_levels(mk_tick(1'b0, 1'b0, 1'b1), 15);
        send_tick(mk_tick(1'b0, 1'b0, 1'b0));
        hold_levels(mk_tick(1'b0, 1'b0, 1'b1), 39);
        send_tick(mk_tick(1'b0, 1'b0, 1'b0));
        hold_levels(mk_tick(1'b0, 1'b0, 1'b1), 40);
        send_tick(mk_tick(1'b0, 1'b0, 1'b0));
        hold_levels(mk_tick(1'b1, 1'b1, 1'b0), 9);
        send_tick(mk_tick(1'b0, 1'b0, 1'b0));

        set_thresholds(4, 9);
        random_phase(120);
        set_thresholds(1, 1);
        random_phase(50);
        set_thresholds(1, 65535);
        random_phase(50);
        set_thresholds(7, 3);
        random_phase(50);

        // receiver holds off while ticks keep coming
        set_thresholds(12, 30);
        stall_asked++;
        random_phase(120);

        // widest thresholds, no hold reaches them
        set_thresholds(65535, 65535);
        hold_levels(mk_tick(1'b0, 1'b0, 1'b0), 2);
        hold_levels(mk_tick(1'b1, 1'b1, 1'b0), 40);
        hold_levels(mk_tick(1'b0, 1'b0, 1'b0), 5);
        hold_levels(mk_tick(1'b1, 1'b1, 1'b0), 2);
        hold_levels(mk_tick(1'b0, 1'b0, 1'b0), 2);
        hold_levels(mk_tick(1'b0, 1'b0, 1'b1), 40);
        send_tick(mk_tick(1'b0, 1'b0, 1'b0));
        hold_levels(mk_tick(1'b0, 1'b0, 1'b1), 3);
        send_tick(mk_tick(1'b0, 1'b0, 1'b0));
        random_phase(30);

        set_thresholds(65535, 1);
        random_phase(30);
        set_thresholds(2, 5);
        random_phase(60);
        set_thresholds(int'(tpsw_pkg::TRIGGER_HOLD_RST), int'(tpsw_pkg::EXIT_HOLD_RST));
        random_phase(30);

        drain_status();
        repeat (8) @(posedge clk);
        if (sb.expected_status.size() != 0)
            sb.report_mismatch("status transactions missing at end");
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
